// ----- src/led_heat_decay_table_unit_defines.svh -----
// Assertion macros shared by the heat table modules.
`ifndef LED_HEAT_DECAY_TABLE_UNIT_DEFINES_SVH
`define LED_HEAT_DECAY_TABLE_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LDHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define LDHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ldht_pkg.sv -----
package ldht_pkg;

  localparam int DEF_LED_COUNT = 64;
  localparam int DEF_MAX_LEVEL = 15;
  localparam int IV_W = 11;

  localparam logic [1:0] CMD_PRESS  = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_RETIME = 2'd2;

  typedef enum logic [1:0] {
    K_PRESS  = 2'd0,
    K_QUERY  = 2'd1,
    K_RETIME = 2'd2,
    K_REJECT = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  led_sel;
    logic [31:0] now;
    logic [7:0]  base_brightness;
  } in_item_t;

  typedef struct packed {
    logic [3:0] heat_level;
    logic [7:0] scaled_brightness;
    logic       accepted;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  idx;
    logic [31:0] now;
    logic [7:0]  bright;
  } job_t;

  function automatic logic [IV_W-1:0] interval_of(input logic [1:0] speed);
    logic [IV_W-1:0] iv;
    case (speed)
      2'd0:    iv = 11'd1200;
      2'd1:    iv = 11'd900;
      2'd2:    iv = 11'd600;
      2'd3:    iv = 11'd300;
      default: iv = 11'd1200;
    endcase
    return iv;
  endfunction

endpackage

// ----- src/ldht_ram.sv -----
module ldht_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ldht_div.sv -----
// Restoring divider, one quotient bit per cycle; results hold until the next start.
module ldht_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [31:0]                 dividend,
  input  logic [ldht_pkg::IV_W-1:0]   divisor,
  output logic                        done,
  output logic [31:0]                 quot,
  output logic [ldht_pkg::IV_W-1:0]   rem
);

  logic                      running;
  logic [4:0]                cnt;
  logic [ldht_pkg::IV_W-1:0] dvs;
  logic [ldht_pkg::IV_W:0]   trial;
  logic                      ge;

  assign trial = {rem, quot[31]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (running) begin
      quot <= {quot[30:0], ge};
      rem  <= ge ? ldht_pkg::IV_W'(trial - {1'b0, dvs}) : trial[ldht_pkg::IV_W-1:0];
    end
  end

endmodule

// ----- src/ldht_front.sv -----
`include "led_heat_decay_table_unit_defines.svh"

// Classify commands and hold them in a two-entry queue for the back end.
module ldht_front #(
  parameter int LED_COUNT = ldht_pkg::DEF_LED_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ldht_pkg::in_item_t item,
  output logic               q_valid,
  output ldht_pkg::job_t     q_job,
  input  logic               pop
);

  ldht_pkg::job_t slots [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;
  logic           push;
  ldht_pkg::job_t job_in;
  logic           in_range;

  assign in_range = {1'b0, item.led_sel} < 9'(LED_COUNT);

  always_comb begin
    job_in.idx    = item.led_sel;
    job_in.now    = item.now;
    job_in.bright = item.base_brightness;
    if (item.command == ldht_pkg::CMD_RETIME) begin
      job_in.kind = ldht_pkg::K_RETIME;
    end else if (item.command == ldht_pkg::CMD_PRESS && in_range) begin
      job_in.kind = ldht_pkg::K_PRESS;
    end else if (item.command == ldht_pkg::CMD_QUERY && in_range) begin
      job_in.kind = ldht_pkg::K_QUERY;
    end else begin
      job_in.kind = ldht_pkg::K_REJECT;
    end
  end

  assign busy    = count == 2'd2;
  assign push    = start && !busy;
  assign q_valid = count != 2'd0;
  assign q_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  `LDHT_ASSERT(a_count_bound, count <= 2'd2, "queue count out of range")
  `LDHT_ASSERT(a_pop_nonempty, !pop || count != 2'd0, "pop from empty queue")

endmodule

// ----- src/ldht_back.sv -----
`include "led_heat_decay_table_unit_defines.svh"

// Carry out queued commands against the entry store.
module ldht_back #(
  parameter int LED_COUNT = ldht_pkg::DEF_LED_COUNT,
  parameter int MAX_LEVEL = ldht_pkg::DEF_MAX_LEVEL
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          decay_speed,
  input  logic                q_valid,
  input  ldht_pkg::job_t      q_job,
  output logic                pop,
  output logic                result_valid,
  output ldht_pkg::out_item_t result
);

  localparam int LW = $clog2(MAX_LEVEL + 1);
  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int DW = LW + 32;
  localparam int PW = 8 + LW;
  // Divide by MAX_LEVEL as a multiply by a rounded-up reciprocal and a shift;
  // SH bits of fraction keep the floor exact for every product below 2^PW.
  localparam int SH = PW + LW;
  localparam int RW = SH + 1;
  localparam logic [RW-1:0] RECIP = RW'(((1 << SH) + MAX_LEVEL - 1) / MAX_LEVEL);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_LOAD  = 6'b000100,
    S_DIV   = 6'b001000,
    S_APPLY = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                    state;
  ldht_pkg::job_t            job;
  logic [IW-1:0]             idx;
  logic [LW-1:0]             lvl;
  logic [31:0]               strt;
  logic [LW-1:0]             res_lvl;
  logic                      res_acc;
  logic [PW-1:0]             prod;
  logic [LED_COUNT-1:0]      vld;

  logic [DW-1:0]             rdata;
  logic [DW-1:0]             wdata;
  logic                      we;
  logic [LW-1:0]             cur_lvl;
  logic                      div_go;
  logic                      div_done;
  logic [31:0]               quot;
  logic [ldht_pkg::IV_W-1:0] rem;
  logic                      gone;
  logic [LW-1:0]             dec_lvl;
  logic [31:0]               dec_start;
  logic [LW-1:0]             new_lvl;
  logic                      last;
  logic [PW+RW-1:0]          scale_prod;

  ldht_ram #(.WIDTH(DW), .DEPTH(LED_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  ldht_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (job.now - rdata[31:0]),
    .divisor  (ldht_pkg::interval_of(decay_speed)),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign pop     = (state == S_IDLE) && q_valid;
  assign cur_lvl = vld[idx] ? rdata[DW-1:32] : '0;
  assign div_go  = (state == S_LOAD) && (cur_lvl != '0);
  assign last    = idx == IW'(LED_COUNT - 1);

  assign scale_prod = (PW+RW)'(prod) * (PW+RW)'(RECIP);

  // Lazy decay of the loaded entry and the write data for each command kind.
  always_comb begin
    gone = quot >= 32'(lvl);
    if (lvl == '0) begin
      dec_lvl   = '0;
      dec_start = strt;
    end else if (gone) begin
      dec_lvl   = '0;
      dec_start = '0;
    end else begin
      dec_lvl   = lvl - LW'(quot);
      dec_start = job.now - 32'(rem);
    end
    new_lvl = (dec_lvl < LW'(MAX_LEVEL)) ? dec_lvl + LW'(1) : LW'(MAX_LEVEL);
    case (job.kind)
      ldht_pkg::K_PRESS:  wdata = {new_lvl, job.now};
      ldht_pkg::K_RETIME: wdata = {dec_lvl, (dec_lvl != '0) ? job.now : dec_start};
      default:            wdata = {dec_lvl, dec_start};
    endcase
  end

  assign we = state == S_APPLY;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vld          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= state == S_OUT;
      if (we) begin
        vld[idx] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= (q_job.kind == ldht_pkg::K_REJECT) ? S_OUT : S_READ;
          end
        end
        S_READ:  state <= S_LOAD;
        S_LOAD:  state <= (cur_lvl != '0) ? S_DIV : S_APPLY;
        S_DIV: begin
          if (div_done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (job.kind == ldht_pkg::K_RETIME && !last) begin
            state <= S_READ;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        job     <= q_job;
        idx     <= (q_job.kind == ldht_pkg::K_RETIME) ? '0 : q_job.idx[IW-1:0];
        res_lvl <= '0;
        res_acc <= q_job.kind != ldht_pkg::K_REJECT;
        prod    <= '0;
      end
      S_LOAD: begin
        lvl  <= cur_lvl;
        strt <= rdata[31:0];
      end
      S_APPLY: begin
        case (job.kind)
          ldht_pkg::K_PRESS: begin
            res_lvl <= new_lvl;
            prod    <= PW'(job.bright) * PW'(new_lvl);
          end
          ldht_pkg::K_QUERY: begin
            res_lvl <= dec_lvl;
            prod    <= PW'(job.bright) * PW'(dec_lvl);
          end
          default: begin
            if (!last) begin
              idx <= idx + IW'(1);
            end
          end
        endcase
      end
      S_OUT: begin
        result.heat_level        <= 4'(res_lvl);
        result.scaled_brightness <= 8'(scale_prod >> SH);
        result.accepted          <= res_acc;
      end
      default: begin
      end
    endcase
  end

  `LDHT_ASSERT_NEXT(a_strobe_pulse, result_valid, !result_valid, "result strobe held")
  `LDHT_ASSERT_NEXT(a_out_strobe, state == S_OUT, result_valid, "missing result strobe")
  `LDHT_ASSERT(a_div_state, !div_done || state == S_DIV, "divider finished outside wait")
  `LDHT_ASSERT(a_pop_idle, !pop || state == S_IDLE, "pop while working")

endmodule

// ----- src/led_heat_decay_table_unit.sv -----
// Per-LED heat table with lazy time-based decay. Issue a command by raising
// start while busy is low; it is taken at that clock edge. Every command gives
// exactly one result, shown on result for one cycle with result_valid high; the
// receiver cannot stall, so capture it in that cycle. A press or query on a lit
// entry leaves the queue, then passes through the registered store read, the
// bit-serial 32-bit divide of the elapsed time by the decay interval, the update
// and the registering of the result. An unlit entry skips the divide. A retime
// walks every entry through the same read, divide (lit entries only) and write.
// Rejected commands skip the store and go straight to the result. Up to two
// commands wait in the queue while one is worked on. Write decay_speed over the
// cfg channel (always ready) only while no command is outstanding.
module led_heat_decay_table_unit #(
  parameter int LED_COUNT = ldht_pkg::DEF_LED_COUNT,
  parameter int MAX_LEVEL = ldht_pkg::DEF_MAX_LEVEL
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ldht_pkg::in_item_t  item,
  output logic                result_valid,
  output ldht_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);

  logic [1:0]     speed;
  logic           q_valid;
  ldht_pkg::job_t q_job;
  logic           pop;

  assign cfg_ready = 1'b1;

  // Hold the decay speed; take a write whenever the channel completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      speed <= cfg_data;
    end
  end

  // Front end: classify and queue transactions.
  ldht_front #(.LED_COUNT(LED_COUNT)) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (pop)
  );

  // Back end: decay, update the store and produce the result.
  ldht_back #(.LED_COUNT(LED_COUNT), .MAX_LEVEL(MAX_LEVEL)) u_back (
    .clk          (clk),
    .rst          (rst),
    .decay_speed  (speed),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
